/* src/sgma_pkg.sv */
// shared types, codes and lookup functions of the staggered grid material averager
package sgma_pkg;

    localparam int FIELD_W = 32;
    localparam int DIV_W   = 51;
    localparam int NUM_MEM = 5;
    localparam int NUM_DIST = 7;

    localparam logic [DIV_W-1:0] RECIP_NUM = DIV_W'(1) << 48;
    localparam logic [DIV_W-1:0] HARM_NUM  = DIV_W'(1) << 50;

    // configuration register indexes
    localparam logic [1:0] CFG_NX    = 2'd0;
    localparam logic [1:0] CFG_NY    = 2'd1;
    localparam logic [1:0] CFG_NZ    = 2'd2;
    localparam logic [1:0] CFG_VISCO = 2'd3;

    // ring store indexes
    localparam logic [2:0] M_C44 = 3'd0;
    localparam logic [2:0] M_C55 = 3'd1;
    localparam logic [2:0] M_C66 = 3'd2;
    localparam logic [2:0] M_TAU = 3'd3;
    localparam logic [2:0] M_RHO = 3'd4;

    // look-back distance codes
    localparam logic [2:0] D_FULL      = 3'd0;  // plane + row + 1
    localparam logic [2:0] D_PLANE_1   = 3'd1;  // plane + 1
    localparam logic [2:0] D_ONE       = 3'd2;
    localparam logic [2:0] D_ROW_1     = 3'd3;  // row + 1
    localparam logic [2:0] D_PLANE_ROW = 3'd4;
    localparam logic [2:0] D_ROW       = 3'd5;
    localparam logic [2:0] D_PLANE     = 3'd6;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

    // store used by each harmonic mean: 0 c66 ij, 1 c44 jk, 2 c55 ik
    function automatic logic [2:0] grp_mem(input logic [1:0] grp);
        logic [2:0] m;
        case (grp)
            2'd0:    m = M_C66;
            2'd1:    m = M_C44;
            default: m = M_C55;
        endcase
        return m;
    endfunction

    // distance of each of the four corners of a harmonic mean
    function automatic logic [2:0] harm_dist(input logic [1:0] grp, input logic [1:0] sub);
        logic [2:0] d;
        d = D_FULL;
        case (grp)
            2'd0: begin
                case (sub)
                    2'd0:    d = D_FULL;
                    2'd1:    d = D_PLANE_1;
                    2'd2:    d = D_ONE;
                    default: d = D_ROW_1;
                endcase
            end
            2'd1: begin
                case (sub)
                    2'd0:    d = D_FULL;
                    2'd1:    d = D_PLANE_ROW;
                    2'd2:    d = D_ROW;
                    default: d = D_ROW_1;
                endcase
            end
            default: begin
                case (sub)
                    2'd0:    d = D_FULL;
                    2'd1:    d = D_PLANE_ROW;
                    2'd2:    d = D_PLANE;
                    default: d = D_PLANE_1;
                endcase
            end
        endcase
        return d;
    endfunction

endpackage

/* src/sgma_in_if.sv */
// input channel: one grid point per request
interface sgma_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] mod_c44;
    logic [31:0] mod_c55;
    logic [31:0] mod_c66;
    logic [31:0] tau_shear;
    logic [31:0] density;

    modport source (output valid, output mod_c44, output mod_c55, output mod_c66,
                    output tau_shear, output density, input ready);
    modport sink   (input valid, input mod_c44, input mod_c55, input mod_c66,
                    input tau_shear, input density, output ready);
endinterface

/* src/sgma_out_if.sv */
// output channel: averaged material values of one interior point
interface sgma_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] c66_avg_ij;
    logic [31:0] c44_avg_jk;
    logic [31:0] c55_avg_ik;
    logic [31:0] tau_avg_ij;
    logic [31:0] tau_avg_jk;
    logic [31:0] tau_avg_ik;
    logic [31:0] rho_avg_j;
    logic [31:0] rho_avg_k;
    logic [31:0] rho_avg_i;
    logic        final_point;

    modport source (output valid, output c66_avg_ij, output c44_avg_jk, output c55_avg_ik,
                    output tau_avg_ij, output tau_avg_jk, output tau_avg_ik,
                    output rho_avg_j, output rho_avg_k, output rho_avg_i,
                    output final_point, input ready);
    modport sink   (input valid, input c66_avg_ij, input c44_avg_jk, input c55_avg_ik,
                    input tau_avg_ij, input tau_avg_jk, input tau_avg_ik,
                    input rho_avg_j, input rho_avg_k, input rho_avg_i,
                    input final_point, output ready);
endinterface

/* src/staggered_grid_material_averager.sv */
// top level: scan tracking, history reads, shared-divider sequencing, result register
//
//  channel  dir  handshake            payload
//  i_in     in   valid/ready          mod_c44 mod_c55 mod_c66 tau_shear density
//  o_out    out  valid/ready          nine averages and final_point
//  i_cfg_*  in   write enable only    2-bit index, 12-bit data
//
// a point with a result goes through the accept, 7 history reads, a store write, 15 divisions
// in the one shared divider (12 reciprocals, 3 harmonic quotients) and the output load;
// a border point without a result goes through the accept and a store write only.
// synchronous reset returns the scan to its origin; history contents are kept.
// a finished result waits in the output register while the next point is taken.
module staggered_grid_material_averager #(
    parameter int MAX_NX     = 64,
    parameter int MAX_NZ     = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    sgma_in_if.sink     i_in,
    sgma_out_if.source  o_out
);

    localparam int RING_DEPTH = (MAX_NX + 1) * (MAX_NZ + 1) + (MAX_NZ + 1) + 1;
    localparam int AW = $clog2(RING_DEPTH);
    localparam int DW = $clog2(RING_DEPTH + 1);
    localparam int VB = VALUE_BITS;
    localparam int W  = sgma_pkg::DIV_W;
    localparam logic [DW:0] DEPTH_EXT = (DW + 1)'(RING_DEPTH);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_READ      = 3'd1;
    localparam logic [2:0] S_WRITE     = 3'd2;
    localparam logic [2:0] S_DIV_START = 3'd3;
    localparam logic [2:0] S_DIV_WAIT  = 3'd4;
    localparam logic [2:0] S_OUT       = 3'd5;

    // configuration
    logic [6:0]  r_nx;
    logic [11:0] r_ny;
    logic [6:0]  r_nz;
    logic        r_visco;
    logic [6:0]  w_nx;
    logic [11:0] w_ny;
    logic [6:0]  w_nz;
    logic [DW-1:0] r_row;
    logic [DW-1:0] r_plane;

    // scan state
    logic [AW-1:0] r_wp;
    logic [6:0]    r_pk;
    logic [6:0]    r_pi;
    logic [11:0]   r_pj;
    logic [2:0]    r_state;
    logic [2:0]    r_dist;
    logic          r_emit;
    logic          r_final;
    logic [1:0]    r_grp;
    logic [2:0]    r_sub;
    logic          r_ov;

    // payload
    logic [sgma_pkg::NUM_MEM-1:0][VB-1:0] r_cur;
    logic [VB-1:0] r_hv   [3][4];
    logic [VB-1:0] r_tau  [sgma_pkg::NUM_DIST];
    logic [VB-1:0] r_rho  [sgma_pkg::NUM_DIST];
    logic [VB-1:0] r_harm [3];
    logic [W-1:0]  r_acc;
    logic [31:0]   r_o_c66, r_o_c44, r_o_c55;
    logic [31:0]   r_o_tij, r_o_tjk, r_o_tik;
    logic [31:0]   r_o_rj, r_o_rk, r_o_ri;
    logic          r_o_fin;

    logic                                 w_acc;
    logic [DW-1:0]                        w_dist;
    logic [AW-1:0]                        w_raddr;
    logic [sgma_pkg::NUM_MEM-1:0][VB-1:0] w_rdata;
    logic                                 w_we;
    sgma_pkg::t_div_req                   w_req;
    sgma_pkg::t_div_rsp                   w_rsp;
    logic                                 w_zero;
    logic [VB-1:0]                        w_sat;
    logic [VB+1:0]                        w_tij, w_tjk, w_tik;
    logic [VB:0]                          w_rj, w_rk, w_ri;
    logic                                 w_load;

    always_comb begin
        if (r_nx == '0) w_nx = 7'd1;
        else if (int'(r_nx) > MAX_NX) w_nx = 7'(MAX_NX);
        else w_nx = r_nx;
        if (r_nz == '0) w_nz = 7'd1;
        else if (int'(r_nz) > MAX_NZ) w_nz = 7'(MAX_NZ);
        else w_nz = r_nz;
        w_ny = (r_ny == '0) ? 12'd1 : r_ny;
    end

    // neighbour distances follow the clamped dimensions
    always_ff @(posedge i_clk) begin
        r_row   <= DW'(w_nz) + 1'b1;
        r_plane <= DW'((DW'(w_nx) + 1'b1) * (DW'(w_nz) + 1'b1));
    end

    assign w_acc       = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_we        = (r_state == S_WRITE);

    always_comb begin
        unique case (r_dist)
            sgma_pkg::D_FULL:      w_dist = DW'(r_plane + r_row + 1'b1);
            sgma_pkg::D_PLANE_1:   w_dist = DW'(r_plane + 1'b1);
            sgma_pkg::D_ONE:       w_dist = DW'(1);
            sgma_pkg::D_ROW_1:     w_dist = DW'(r_row + 1'b1);
            sgma_pkg::D_PLANE_ROW: w_dist = DW'(r_plane + r_row);
            sgma_pkg::D_ROW:       w_dist = r_row;
            default:               w_dist = r_plane;
        endcase
        // wrap the look-back address around the ring
        if ((DW + 1)'(r_wp) >= (DW + 1)'(w_dist)) begin
            w_raddr = AW'((DW + 1)'(r_wp) - (DW + 1)'(w_dist));
        end else begin
            w_raddr = AW'((DW + 1)'(r_wp) + DEPTH_EXT - (DW + 1)'(w_dist));
        end
    end

    sgma_ring #(.DEPTH(RING_DEPTH), .AW(AW), .VB(VB)) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (r_cur),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_req.start = (r_state == S_DIV_START);
        if (r_sub == 3'd4) begin
            w_req.num = sgma_pkg::HARM_NUM;
            w_req.den = r_acc;
        end else begin
            w_req.num = sgma_pkg::RECIP_NUM;
            w_req.den = W'(r_hv[r_grp][r_sub[1:0]]);
        end
    end

    sgma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_zero = 1'b0;
        for (int s = 0; s < 4; s++) begin
            if (r_hv[r_grp][s] == '0) w_zero = 1'b1;
        end
        if (w_rsp.quo[W-1:VB] != '0) w_sat = '1;
        else w_sat = VB'(w_rsp.quo);
        w_tij = (VB + 2)'(r_tau[sgma_pkg::D_FULL]) + (VB + 2)'(r_tau[sgma_pkg::D_PLANE_1])
              + (VB + 2)'(r_tau[sgma_pkg::D_ONE]) + (VB + 2)'(r_tau[sgma_pkg::D_ROW_1]);
        w_tjk = (VB + 2)'(r_tau[sgma_pkg::D_FULL]) + (VB + 2)'(r_tau[sgma_pkg::D_ROW_1])
              + (VB + 2)'(r_tau[sgma_pkg::D_ROW]) + (VB + 2)'(r_tau[sgma_pkg::D_PLANE_ROW]);
        w_tik = (VB + 2)'(r_tau[sgma_pkg::D_FULL]) + (VB + 2)'(r_tau[sgma_pkg::D_PLANE_1])
              + (VB + 2)'(r_tau[sgma_pkg::D_PLANE]) + (VB + 2)'(r_tau[sgma_pkg::D_PLANE_ROW]);
        w_rj = (VB + 1)'(r_rho[sgma_pkg::D_FULL]) + (VB + 1)'(r_rho[sgma_pkg::D_ROW_1]);
        w_rk = (VB + 1)'(r_rho[sgma_pkg::D_FULL]) + (VB + 1)'(r_rho[sgma_pkg::D_PLANE_ROW]);
        w_ri = (VB + 1)'(r_rho[sgma_pkg::D_FULL]) + (VB + 1)'(r_rho[sgma_pkg::D_PLANE_1]);
    end

    assign w_load = (r_state == S_OUT) && (!r_ov || o_out.ready);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx    <= 7'd64;
            r_ny    <= 12'd64;
            r_nz    <= 7'd64;
            r_visco <= 1'b0;
            r_wp    <= '0;
            r_pk    <= '0;
            r_pi    <= '0;
            r_pj    <= '0;
            r_state <= S_IDLE;
            r_dist  <= '0;
            r_emit  <= 1'b0;
            r_grp   <= '0;
            r_sub   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_load) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sgma_pkg::CFG_NX: begin
                        r_nx <= i_cfg_data[6:0];
                        r_wp <= '0; r_pk <= '0; r_pi <= '0; r_pj <= '0;
                    end
                    sgma_pkg::CFG_NY: begin
                        r_ny <= i_cfg_data;
                        r_wp <= '0; r_pk <= '0; r_pi <= '0; r_pj <= '0;
                    end
                    sgma_pkg::CFG_NZ: begin
                        r_nz <= i_cfg_data[6:0];
                        r_wp <= '0; r_pk <= '0; r_pi <= '0; r_pj <= '0;
                    end
                    default: r_visco <= i_cfg_data[0];
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_emit <= (r_pj != '0) && (r_pi != '0) && (r_pk != '0);
                        r_dist <= '0;
                        if (r_pk >= w_nz) begin
                            r_pk <= '0;
                            if (r_pi >= w_nx) begin
                                r_pi <= '0;
                                r_pj <= (r_pj >= w_ny) ? 12'd0 : r_pj + 1'b1;
                            end else begin
                                r_pi <= r_pi + 1'b1;
                            end
                        end else begin
                            r_pk <= r_pk + 1'b1;
                        end
                        if ((r_pj != '0) && (r_pi != '0) && (r_pk != '0)) r_state <= S_READ;
                        else r_state <= S_WRITE;
                    end
                end
                S_READ: begin
                    r_dist <= r_dist + 1'b1;
                    if (r_dist == 3'(sgma_pkg::NUM_DIST)) r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_wp  <= (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    r_grp <= '0;
                    r_sub <= '0;
                    r_state <= r_emit ? S_DIV_START : S_IDLE;
                end
                S_DIV_START: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (w_rsp.done) begin
                        if (r_sub != 3'd4) begin
                            r_sub   <= r_sub + 1'b1;
                            r_state <= S_DIV_START;
                        end else begin
                            r_sub <= '0;
                            if (r_grp == 2'd2) begin
                                r_state <= S_OUT;
                            end else begin
                                r_grp   <= r_grp + 1'b1;
                                r_state <= S_DIV_START;
                            end
                        end
                    end
                end
                S_OUT: begin
                    if (w_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cur[sgma_pkg::M_C44] <= i_in.mod_c44[VB-1:0];
            r_cur[sgma_pkg::M_C55] <= i_in.mod_c55[VB-1:0];
            r_cur[sgma_pkg::M_C66] <= i_in.mod_c66[VB-1:0];
            r_cur[sgma_pkg::M_TAU] <= i_in.tau_shear[VB-1:0];
            r_cur[sgma_pkg::M_RHO] <= i_in.density[VB-1:0];
            r_final <= (r_pj == w_ny) && (r_pi == w_nx) && (r_pk == w_nz);
        end
        // read data is registered and arrives in the cycle after its address
        if (r_state == S_READ && r_dist != '0) begin
            for (int g = 0; g < 3; g++) begin
                for (int s = 0; s < 4; s++) begin
                    if (sgma_pkg::harm_dist(2'(g), 2'(s)) == 3'(r_dist - 1'b1)) begin
                        r_hv[g][s] <= w_rdata[sgma_pkg::grp_mem(2'(g))];
                    end
                end
            end
            r_tau[3'(r_dist - 1'b1)] <= w_rdata[sgma_pkg::M_TAU];
            r_rho[3'(r_dist - 1'b1)] <= w_rdata[sgma_pkg::M_RHO];
        end
        if (r_state == S_WRITE) r_acc <= '0;
        if (r_state == S_DIV_WAIT && w_rsp.done) begin
            if (r_sub != 3'd4) begin
                r_acc <= r_acc + w_rsp.quo;
            end else begin
                r_acc <= '0;
                r_harm[r_grp] <= w_zero ? '0 : w_sat;
            end
        end
        if (w_load) begin
            r_o_c66 <= 32'(r_harm[0]);
            r_o_c44 <= 32'(r_harm[1]);
            r_o_c55 <= 32'(r_harm[2]);
            r_o_tij <= r_visco ? 32'(w_tij[VB+1:2]) : 32'd0;
            r_o_tjk <= r_visco ? 32'(w_tjk[VB+1:2]) : 32'd0;
            r_o_tik <= r_visco ? 32'(w_tik[VB+1:2]) : 32'd0;
            r_o_rj  <= 32'(w_rj[VB:1]);
            r_o_rk  <= 32'(w_rk[VB:1]);
            r_o_ri  <= 32'(w_ri[VB:1]);
            r_o_fin <= r_final;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.c66_avg_ij  = r_o_c66;
    assign o_out.c44_avg_jk  = r_o_c44;
    assign o_out.c55_avg_ik  = r_o_c55;
    assign o_out.tau_avg_ij  = r_o_tij;
    assign o_out.tau_avg_jk  = r_o_tjk;
    assign o_out.tau_avg_ik  = r_o_tik;
    assign o_out.rho_avg_j   = r_o_rj;
    assign o_out.rho_avg_k   = r_o_rk;
    assign o_out.rho_avg_i   = r_o_ri;
    assign o_out.final_point = r_o_fin;

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp < AW'(RING_DEPTH - 1) || r_wp == AW'(RING_DEPTH - 1))
        else $error("ring pointer beyond ring depth");

    a_div_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV_START |-> !w_rsp.busy)
        else $error("divider started while busy");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state) == S_OUT)
        else $error("result raised outside of output state");

    a_pos_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pk <= w_nz && r_pi <= w_nx)
        else $error("scan position outside the grid");

endmodule

/* src/sgma_ring.sv */
// plane-plus-row history stores, one write and one registered read port each
module sgma_ring #(
    parameter int DEPTH = 4291,
    parameter int AW    = 13,
    parameter int VB    = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [AW-1:0]                          i_waddr,
    input  logic [sgma_pkg::NUM_MEM-1:0][VB-1:0]   i_wdata,
    input  logic [AW-1:0]                          i_raddr,
    output logic [sgma_pkg::NUM_MEM-1:0][VB-1:0]   o_rdata
);

    for (genvar g = 0; g < sgma_pkg::NUM_MEM; g++) begin : g_store
        logic [VB-1:0] mem [DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_we) begin
                mem[i_waddr] <= i_wdata[g];
            end
            o_rdata[g] <= mem[i_raddr];
        end
    end

endmodule

/* src/sgma_div.sv */
// shared restoring divider, one quotient bit per cycle
module sgma_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sgma_pkg::t_div_req  i_req,
    output sgma_pkg::t_div_rsp  o_rsp
);

    localparam int W = sgma_pkg::DIV_W;

    logic [W-1:0]         r_num;
    logic [W-1:0]         r_den;
    logic [W-1:0]         r_rem;
    logic [W-1:0]         r_quo;
    logic [$clog2(W)-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [W:0]   w_trial;
    logic         w_ge;
    logic [W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_num[W-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        n_rem   = w_ge ? W'(w_trial - {1'b0, r_den}) : W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_cnt <= $clog2(W)'(W - 1);
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= n_rem;
            r_quo <= {r_quo[W-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
